/* sv/crc32rx_pkg.sv */
// Shared types, constants and the CRC byte update for the CRC-32 packet receiver.
`default_nettype none
package crc32rx_pkg;

	// Field widths
	localparam int unsigned SIZE_W  = 16;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned CRC_W   = 32;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned CFG_IDX_W = 8;

	// Command queue between front and back
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = QPTR_W + 1;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SIZE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 8'd1;
	localparam logic [SIZE_W-1:0]    PACKET_SIZE_RST   = 16'd64;
	localparam logic [MS_W-1:0]      TIMEOUT_LIMIT_RST = 16'hFFFF;

	// Input action codes
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// Result kind codes
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_REPLY   = 2'd1;
	localparam logic [1:0] KIND_OUTCOME = 2'd2;

	// Outcome codes
	localparam logic OUTCOME_GOOD    = 1'b0;
	localparam logic OUTCOME_TIMEOUT = 1'b1;

	// CRC constants
	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

	// Reply characters
	localparam logic [7:0] CH_NL = 8'h0A;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] line_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic       outcome;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_PAYLOAD,
		CMD_TIMEOUT,
		CMD_ACK_OK,
		CMD_ACK_BAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	// Fold one byte into a reflected CRC-32
	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Character of the TRU/FAL reply at a given position
	function automatic logic [7:0] reply_char(input logic ok, input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0:    ch = ok ? 8'h54 : 8'h46; // T / F
			2'd1:    ch = ok ? 8'h52 : 8'h41; // R / A
			2'd2:    ch = ok ? 8'h55 : 8'h4C; // U / L
			default: ch = CH_NL;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

/* sv/crc32rx_queue.sv */
// Short command queue between the receive front end and the result back end.
`default_nettype none
module crc32rx_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  crc32rx_pkg::cmd_t     push_cmd,
	output logic                  full,
	input  wire                   pop,
	output crc32rx_pkg::cmd_t     head,
	output logic                  head_valid
);

	crc32rx_pkg::cmd_t                  mem_q [crc32rx_pkg::QDEPTH];
	logic [crc32rx_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [crc32rx_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [crc32rx_pkg::QCNT_W-1:0]     count_q;

	assign full       = (count_q == crc32rx_pkg::QCNT_W'(crc32rx_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/crc32rx_front.sv */
// Front end: configuration registers, session state, CRC check and command issue.
`default_nettype none
module crc32rx_front (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  crc32rx_pkg::in_item_t                  in_data,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire [crc32rx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [15:0]                             cfg_data,
	input  wire                                    q_full,
	output logic                                   push,
	output crc32rx_pkg::cmd_t                      push_cmd
);

	logic [crc32rx_pkg::SIZE_W-1:0]  psize_q;
	logic [crc32rx_pkg::MS_W-1:0]    tlimit_q;
	logic                            session_q;
	logic [crc32rx_pkg::COUNT_W-1:0] count_q;
	logic [crc32rx_pkg::CRC_W-1:0]   crc_q;
	logic [crc32rx_pkg::CRC_W-1:0]   rcrc_q;
	logic [crc32rx_pkg::MS_W-1:0]    elapsed_q;

	logic                            accept;
	logic [crc32rx_pkg::MS_W-1:0]    elapsed_nxt;
	logic                            timed_out;
	logic                            is_payload;
	logic [crc32rx_pkg::COUNT_W-1:0] offset;
	logic [crc32rx_pkg::CRC_W-1:0]   rcrc_nxt;
	logic                            crc_done;
	logic                            crc_match;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	// Classify the current item
	always_comb begin
		elapsed_nxt = elapsed_q + 1'b1;
		timed_out   = (elapsed_nxt >= tlimit_q) || (elapsed_nxt == '0);
		is_payload  = (count_q < {1'b0, psize_q});
		offset      = count_q - {1'b0, psize_q};
		rcrc_nxt    = rcrc_q | ({24'd0, in_data.line_byte} << {offset[1:0], 3'b000});
		crc_done    = (offset >= crc32rx_pkg::COUNT_W'(3));
		crc_match   = ((crc_q ^ crc32rx_pkg::CRC_INIT) == rcrc_nxt);
	end

	// Issue a command for items that cause results
	always_comb begin
		push          = 1'b0;
		push_cmd.kind = crc32rx_pkg::CMD_PAYLOAD;
		push_cmd.data = in_data.line_byte;
		if (accept && session_q) begin
			case (in_data.action)
				crc32rx_pkg::ACT_TICK: begin
					push          = timed_out;
					push_cmd.kind = crc32rx_pkg::CMD_TIMEOUT;
				end
				crc32rx_pkg::ACT_BYTE: begin
					if (is_payload) begin
						push = 1'b1;
					end else begin
						push          = crc_done;
						push_cmd.kind = crc_match ? crc32rx_pkg::CMD_ACK_OK
							: crc32rx_pkg::CMD_ACK_BAD;
					end
				end
				default: push = 1'b0;
			endcase
		end
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q  <= crc32rx_pkg::PACKET_SIZE_RST;
			tlimit_q <= crc32rx_pkg::TIMEOUT_LIMIT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == crc32rx_pkg::CFG_PACKET_SIZE) begin
				psize_q <= cfg_data;
			end else if (cfg_index == crc32rx_pkg::CFG_TIMEOUT_LIMIT) begin
				tlimit_q <= cfg_data;
			end
		end
	end

	// Advance session state on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= 1'b0;
			count_q   <= '0;
			crc_q     <= crc32rx_pkg::CRC_INIT;
			rcrc_q    <= '0;
			elapsed_q <= '0;
		end else if (accept) begin
			case (in_data.action)
				crc32rx_pkg::ACT_START: begin
					session_q <= 1'b1;
					count_q   <= '0;
					crc_q     <= crc32rx_pkg::CRC_INIT;
					rcrc_q    <= '0;
					elapsed_q <= '0;
				end
				crc32rx_pkg::ACT_TICK: begin
					if (session_q) begin
						elapsed_q <= elapsed_nxt;
						if (timed_out) begin
							session_q <= 1'b0;
						end
					end
				end
				crc32rx_pkg::ACT_BYTE: begin
					if (session_q) begin
						if (is_payload) begin
							crc_q   <= crc32rx_pkg::crc_fold(crc_q, in_data.line_byte);
							count_q <= count_q + 1'b1;
						end else if (!crc_done) begin
							rcrc_q  <= rcrc_nxt;
							count_q <= count_q + 1'b1;
						end else begin
							// restart the attempt; close on a good packet
							count_q <= '0;
							crc_q   <= crc32rx_pkg::CRC_INIT;
							rcrc_q  <= '0;
							if (crc_match) begin
								session_q <= 1'b0;
							end
						end
					end
				end
				default: session_q <= session_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/crc32rx_back.sv */
// Back end: expand queued commands into result items behind an output register.
`default_nettype none
module crc32rx_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  crc32rx_pkg::cmd_t       head,
	input  wire                     head_valid,
	output logic                    pop,
	output logic                    out_valid,
	input  wire                     out_stall,
	output crc32rx_pkg::out_item_t  out_data
);

	logic [2:0]                 idx_q;
	logic                       out_valid_q;
	crc32rx_pkg::out_item_t     out_data_q;
	crc32rx_pkg::out_item_t     item;
	logic                       load;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && head_valid && item.last;

	// Build the next result item of the head command
	always_comb begin
		item.kind       = crc32rx_pkg::KIND_PAYLOAD;
		item.byte_value = head.data;
		item.outcome    = crc32rx_pkg::OUTCOME_GOOD;
		item.last       = 1'b1;
		case (head.kind)
			crc32rx_pkg::CMD_PAYLOAD: begin
				item.kind = crc32rx_pkg::KIND_PAYLOAD;
			end
			crc32rx_pkg::CMD_TIMEOUT: begin
				item.kind       = crc32rx_pkg::KIND_OUTCOME;
				item.byte_value = '0;
				item.outcome    = crc32rx_pkg::OUTCOME_TIMEOUT;
			end
			crc32rx_pkg::CMD_ACK_OK: begin
				if (idx_q[2]) begin
					item.kind       = crc32rx_pkg::KIND_OUTCOME;
					item.byte_value = '0;
				end else begin
					item.kind       = crc32rx_pkg::KIND_REPLY;
					item.byte_value = crc32rx_pkg::reply_char(1'b1, idx_q[1:0]);
					item.last       = 1'b0;
				end
			end
			default: begin
				item.kind       = crc32rx_pkg::KIND_REPLY;
				item.byte_value = crc32rx_pkg::reply_char(1'b0, idx_q[1:0]);
				item.last       = (idx_q[1:0] == 2'd3);
			end
		endcase
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_data_q <= item;
		end
	end

	// Advance position within the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= item.last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/crc32_packet_receiver_with_ack.sv */
// Top level of the CRC-32 framed packet receiver with TRU/FAL acknowledgement.
//
// Input channel (in_valid/in_stall/in_data): start, line byte or millisecond
// tick, one transfer per cycle while in_stall is low. Output channel
// (out_valid/out_stall/out_data): payload bytes for the host, reply characters for
// the line and the session outcome; the final item from an input carries last.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 packet size,
// index 1 timeout limit; always ready, write only while the block is idle.
// An input's command is queued; its results leave via the output register.
// When unstalled: one input per cycle; a payload byte gives one result per cycle,
// a CRC verdict gives four or five results, one per cycle at the output register.
// A four-entry command queue lets the front keep taking inputs while the output
// drains; when the receiver stalls and the queue fills, in_stall rises.
// Reset: session closed, packet size 64, timeout limit 65535, output empty.
`default_nettype none
module crc32_packet_receiver_with_ack (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  crc32rx_pkg::in_item_t               in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output crc32rx_pkg::out_item_t              out_data,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [crc32rx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [15:0]                          cfg_data
);

	logic                   q_full;
	logic                   push;
	crc32rx_pkg::cmd_t      push_cmd;
	logic                   pop;
	crc32rx_pkg::cmd_t      head;
	logic                   head_valid;

	crc32rx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	crc32rx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	crc32rx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the CRC-32 packet receiver with TRU/FAL acknowledgement.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  ACT_RESERVED   = 2'd3;
	localparam logic [31:0] TEXT_TRU       = "TRU\n";
	localparam logic [31:0] TEXT_FAL       = "FAL\n";
	localparam int          LAT_WAIT       = 8;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          RANDOM_ITEMS   = 360;

	// Tracks session state and queues the results each input transfer should cause
	class rx_session_predictor;
		logic [15:0] pkt_len;
		logic [15:0] ms_limit;
		bit          open_flag;
		logic [16:0] taken;
		logic [31:0] crc_reg;
		logic [31:0] fcs_seen;
		logic [15:0] ms_count;
		crc32rx_pkg::out_item_t owed[$];
		int          errors;

		function new();
			pkt_len   = crc32rx_pkg::PACKET_SIZE_RST;
			ms_limit  = crc32rx_pkg::TIMEOUT_LIMIT_RST;
			open_flag = 1'b0;
			ms_count  = '0;
			errors    = 0;
			fresh_attempt();
		endfunction

		// Bitwise reflected update; the data bit steers the feedback directly
		static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			r = c;
			for (int k = 0; k < 8; k++) begin
				r = (r >> 1) ^ ((r[0] ^ b[k]) ? crc32rx_pkg::CRC_POLY : 32'd0);
			end
			return r;
		endfunction

		function void fresh_attempt();
			taken    = '0;
			crc_reg  = crc32rx_pkg::CRC_INIT;
			fcs_seen = '0;
		endfunction

		function void set_reg(logic [crc32rx_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == crc32rx_pkg::CFG_PACKET_SIZE) begin
				pkt_len = val;
			end else if (idx == crc32rx_pkg::CFG_TIMEOUT_LIMIT) begin
				ms_limit = val;
			end
		endfunction

		function void owe(logic [1:0] k, logic [7:0] v, logic o, logic l);
			crc32rx_pkg::out_item_t r;
			r.kind       = k;
			r.byte_value = v;
			r.outcome    = o;
			r.last       = l;
			owed.push_back(r);
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void take_input(crc32rx_pkg::in_item_t it);
			logic [16:0] off;
			logic [31:0] text;
			bit          good;
			if (it.action == crc32rx_pkg::ACT_START) begin
				open_flag = 1'b1;
				fresh_attempt();
				ms_count = '0;
				return;
			end
			if (!open_flag) begin
				return;
			end
			case (it.action)
				crc32rx_pkg::ACT_TICK: begin
					ms_count++;
					if (ms_count >= ms_limit || ms_count == 16'd0) begin
						open_flag = 1'b0;
						owe(crc32rx_pkg::KIND_OUTCOME, 8'd0, crc32rx_pkg::OUTCOME_TIMEOUT,
							1'b1);
					end
				end
				crc32rx_pkg::ACT_BYTE: begin
					if (taken < {1'b0, pkt_len}) begin
						crc_reg = crc_step(crc_reg, it.line_byte);
						taken++;
						owe(crc32rx_pkg::KIND_PAYLOAD, it.line_byte, 1'b0, 1'b1);
					end else begin
						// Trailing CRC bytes, least significant first
						off = taken - {1'b0, pkt_len};
						fcs_seen |= {24'd0, it.line_byte} << (8 * off[1:0]);
						taken++;
						if (off >= 17'd3) begin
							good = (~crc_reg == fcs_seen);
							text = good ? TEXT_TRU : TEXT_FAL;
							for (int i = 0; i < 4; i++) begin
								owe(crc32rx_pkg::KIND_REPLY, text[31-8*i -: 8], 1'b0,
									!good && i == 3);
							end
							if (good) begin
								owe(crc32rx_pkg::KIND_OUTCOME, 8'd0,
									crc32rx_pkg::OUTCOME_GOOD, 1'b1);
								open_flag = 1'b0;
							end
							fresh_attempt();
						end
					end
				end
				default: begin
				end
			endcase
		endfunction

		function int field_diff(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void check_result(crc32rx_pkg::out_item_t got);
			crc32rx_pkg::out_item_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: result with nothing owed, expected none, actual %h", $time, got);
				return;
			end
			want = owed.pop_front();
			errors += field_diff("kind", want.kind, got.kind);
			errors += field_diff("byte_value", want.byte_value, got.byte_value);
			errors += field_diff("outcome", want.outcome, got.outcome);
			errors += field_diff("last", want.last, got.last);
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	crc32rx_pkg::in_item_t  in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	crc32rx_pkg::out_item_t out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [crc32rx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]            cfg_data  = '0;

	bit                   calm = 1'b0;
	int                   items_sent = 0;
	int                   quiet_cycles = 0;
	rx_session_predictor  session;

	crc32_packet_receiver_with_ack DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit want_gap();
		return !calm && ($urandom_range(0, 99) < 26);
	endfunction

	// Stall the output at random
	always @(negedge clk) begin
		out_stall <= want_gap();
	end

	// Check every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			session.check_result(out_data);
		end
	end

	// Abort when nothing has moved for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Drive one input transfer; entered and left at a falling edge
	task automatic send(input logic [1:0] act, input logic [7:0] b);
		crc32rx_pkg::in_item_t it;
		it.action    = act;
		it.line_byte = b;
		while (want_gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		session.take_input(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Hold the input until every owed result has arrived and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (session.pending() != 0) @(posedge clk);
		repeat (LAT_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [crc32rx_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		session.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Send n random payload bytes and their CRC, optionally with one bit flipped
	task automatic send_packet(input int unsigned n, input bit corrupt,
			input int unsigned tick_pct);
		logic [31:0] acc;
		logic [31:0] fcs;
		logic [7:0]  b;
		acc = crc32rx_pkg::CRC_INIT;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < tick_pct) begin
				send(crc32rx_pkg::ACT_TICK, 8'($urandom));
			end
			b   = 8'($urandom);
			acc = rx_session_predictor::crc_step(acc, b);
			send(crc32rx_pkg::ACT_BYTE, b);
		end
		fcs = ~acc;
		if (corrupt) begin
			fcs ^= 32'd1 << $urandom_range(0, 31);
		end
		for (int k = 0; k < 4; k++) begin
			send(crc32rx_pkg::ACT_BYTE, fcs[8*k +: 8]);
		end
	endtask

	initial begin
		int          goal;
		int          r;
		int unsigned psize;
		bit          corrupt;

		session = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Ignored inputs: no session yet, and the unused action code
		send(crc32rx_pkg::ACT_TICK, 8'h3C);
		send(crc32rx_pkg::ACT_BYTE, 8'hA5);
		send(ACT_RESERVED, 8'h5A);

		// Empty payload: the CRC must be zero; zero timeout fires on the first tick
		settle();
		write_reg(crc32rx_pkg::CFG_PACKET_SIZE, 16'd0);
		write_reg(crc32rx_pkg::CFG_TIMEOUT_LIMIT, 16'd0);
		send(crc32rx_pkg::ACT_START, 8'h00);
		send_packet(0, 1'b0, 0);
		send(crc32rx_pkg::ACT_START, 8'hFF);
		send(crc32rx_pkg::ACT_TICK, 8'h00);

		// Restart while open, failed attempt keeps the elapsed time running
		settle();
		write_reg(crc32rx_pkg::CFG_PACKET_SIZE, 16'd1);
		write_reg(crc32rx_pkg::CFG_TIMEOUT_LIMIT, 16'd3);
		send(crc32rx_pkg::ACT_START, 8'h00);
		send(crc32rx_pkg::ACT_BYTE, 8'hFF);
		send(crc32rx_pkg::ACT_START, 8'h00);
		send(crc32rx_pkg::ACT_TICK, 8'h00);
		send_packet(1, 1'b1, 0);
		send(crc32rx_pkg::ACT_TICK, 8'h00);
		send(crc32rx_pkg::ACT_TICK, 8'h00);

		// Shrink the packet size part way through an attempt
		settle();
		write_reg(crc32rx_pkg::CFG_PACKET_SIZE, 16'd6);
		write_reg(crc32rx_pkg::CFG_TIMEOUT_LIMIT, 16'd100);
		send(crc32rx_pkg::ACT_START, 8'h00);
		repeat (5) send(crc32rx_pkg::ACT_BYTE, 8'($urandom));
		settle();
		write_reg(crc32rx_pkg::CFG_PACKET_SIZE, 16'd1);
		send(crc32rx_pkg::ACT_BYTE, 8'($urandom));

		// Random phases, each under its own register settings
		goal = items_sent + RANDOM_ITEMS;
		for (int ph = 0; items_sent < goal; ph++) begin
			settle();
			calm  = (ph == 0);
			psize = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			write_reg(crc32rx_pkg::CFG_PACKET_SIZE, 16'(psize));
			write_reg(crc32rx_pkg::CFG_TIMEOUT_LIMIT, ($urandom_range(0, 3) == 0) ?
				16'($urandom_range(1, 12)) : 16'($urandom_range(40, 600)));
			repeat (calm ? 20 : $urandom_range(3, 8)) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					// well-formed session: retry after a bad CRC, stop after a good one
					send(crc32rx_pkg::ACT_START, 8'($urandom));
					repeat ($urandom_range(1, 3)) begin
						corrupt = $urandom_range(0, 99) < 35;
						send_packet(psize, corrupt, 8);
						if (!corrupt) break;
					end
				end else if (r < 85) begin
					// broken session: cut short anywhere
					send(crc32rx_pkg::ACT_START, 8'($urandom));
					repeat ($urandom_range(0, psize + 3)) begin
						send(crc32rx_pkg::ACT_BYTE, 8'($urandom));
					end
				end else begin
					repeat ($urandom_range(1, 6)) begin
						send(2'($urandom_range(crc32rx_pkg::ACT_START, ACT_RESERVED)),
							8'($urandom));
					end
				end
			end
		end
		calm = 1'b0;

		// Largest timeout: a run of ticks stays well short of the limit
		settle();
		write_reg(crc32rx_pkg::CFG_PACKET_SIZE, 16'd4);
		write_reg(crc32rx_pkg::CFG_TIMEOUT_LIMIT, 16'hFFFF);
		send(crc32rx_pkg::ACT_START, 8'h00);
		send_packet(4, 1'b1, 0);
		repeat (20) send(crc32rx_pkg::ACT_TICK, 8'($urandom));

		// Largest packet size: part of a packet, then time out
		settle();
		write_reg(crc32rx_pkg::CFG_PACKET_SIZE, 16'hFFFF);
		write_reg(crc32rx_pkg::CFG_TIMEOUT_LIMIT, 16'd20);
		send(crc32rx_pkg::ACT_START, 8'h00);
		repeat (60) send(crc32rx_pkg::ACT_BYTE, 8'($urandom));
		repeat (20) send(crc32rx_pkg::ACT_TICK, 8'($urandom));

		settle();
		if (session.errors == 0 && session.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* crc32_packet_receiver_with_ack.f */
sv/crc32rx_pkg.sv
sv/crc32rx_queue.sv
sv/crc32rx_front.sv
sv/crc32rx_back.sv
sv/crc32_packet_receiver_with_ack.sv
bench/tb_top.sv
